>>> hdl/sfta_pkg.sv
// ----------------------------------------------------------------------------
// sfta_pkg
// Shared types and constants of the strip and fan triangle assembler.
// ----------------------------------------------------------------------------
package sfta_pkg;

   localparam int WordWidth  = 16;
   localparam int IndexWidth = 15;

   // position of a word inside a four-word vertex record
   localparam logic [1:0] FieldVertex = 2'd0;
   localparam logic [1:0] FieldNormal = 2'd1;
   localparam logic [1:0] FieldS      = 2'd2;
   localparam logic [1:0] FieldT      = 2'd3;

   // corner codes of an emitted triangle
   localparam logic [1:0] CornerFirst  = 2'd0;
   localparam logic [1:0] CornerSecond = 2'd1;
   localparam logic [1:0] CornerLast   = 2'd2;

   typedef struct packed {
      logic [IndexWidth-1:0]       vertex_index;
      logic [IndexWidth-1:0]       normal_index;
      logic signed [WordWidth-1:0] tex_s;
      logic signed [WordWidth-1:0] tex_t;
   } corner_type;

endpackage

>>> hdl/strip_fan_triangle_assembler.sv
// ----------------------------------------------------------------------------
// strip_fan_triangle_assembler
// Assembles triangles from a strip and fan command word stream.
// ----------------------------------------------------------------------------
// At most one word is taken per cycle. A nonzero count word opens a strip
// (positive) or a fan (negative, magnitude is the vertex count); a zero count
// is skipped. Each vertex is four words: vertex index, normal index, s, t.
// From the third vertex of a command on, the last word of every record
// emits one triangle as three result words, slots 0, 1, 2, the third marked
// with rsp_last_corner. Corners are read straight from the three corner
// slots, so the word that completes the next record waits until the three
// corners are taken; with a free output side it never has to wait, since a
// record spans four words and a triangle three, and the block keeps one word
// per cycle. Index words are passed on as their low 15 bits.
module strip_fan_triangle_assembler (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [sfta_pkg::WordWidth-1:0] req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sfta_pkg::IndexWidth-1:0]       rsp_vertex_index,
   output logic [sfta_pkg::IndexWidth-1:0]       rsp_normal_index,
   output logic signed [sfta_pkg::WordWidth-1:0] rsp_tex_s,
   output logic signed [sfta_pkg::WordWidth-1:0] rsp_tex_t,
   output logic                                  rsp_last_corner
);

   logic                                awaiting_ff, awaiting_in;
   logic                                fan_ff, fan_in;
   logic [sfta_pkg::WordWidth-1:0]      left_ff, left_in;
   logic [sfta_pkg::WordWidth-1:0]      ordinal_ff, ordinal_in;
   logic [1:0]                          field_ff, field_in;
   logic [sfta_pkg::IndexWidth-1:0]     part_vertex_ff, part_vertex_in;
   logic [sfta_pkg::IndexWidth-1:0]     part_normal_ff, part_normal_in;
   logic signed [sfta_pkg::WordWidth-1:0] part_s_ff, part_s_in;
   sfta_pkg::corner_type                slot_ff [3];
   sfta_pkg::corner_type                slot_in [3];
   logic                                busy_ff, busy_in;
   logic [1:0]                          corner_ff, corner_in;

   logic                                req_fire;
   logic                                rsp_fire;
   logic                                record_done;
   logic                                emit;
   sfta_pkg::corner_type                rec;
   sfta_pkg::corner_type                out_corner;

   assign req_ready   = !busy_ff || awaiting_ff || (field_ff != sfta_pkg::FieldT);
   assign req_fire    = req_valid && req_ready;
   assign rsp_fire    = rsp_valid && rsp_ready;
   assign record_done = req_fire && !awaiting_ff && (field_ff == sfta_pkg::FieldT);
   assign emit        = record_done && (ordinal_ff[sfta_pkg::WordWidth-1:1] != '0);

   always_comb begin
      rec.vertex_index = part_vertex_ff;
      rec.normal_index = part_normal_ff;
      rec.tex_s        = part_s_ff;
      rec.tex_t        = req_word;
   end

   // command parsing and slot update
   always_comb begin
      awaiting_in    = awaiting_ff;
      fan_in         = fan_ff;
      left_in        = left_ff;
      ordinal_in     = ordinal_ff;
      field_in       = field_ff;
      part_vertex_in = part_vertex_ff;
      part_normal_in = part_normal_ff;
      part_s_in      = part_s_ff;
      slot_in        = slot_ff;
      if (req_fire) begin
         if (awaiting_ff) begin
            if (req_word != '0) begin
               fan_in      = req_word[sfta_pkg::WordWidth-1];
               left_in     = req_word[sfta_pkg::WordWidth-1] ? (~req_word + 1'b1) : req_word;
               ordinal_in  = '0;
               field_in    = sfta_pkg::FieldVertex;
               awaiting_in = 1'b0;
            end
         end else begin
            unique case (field_ff)
               sfta_pkg::FieldVertex: begin
                  part_vertex_in = req_word[sfta_pkg::IndexWidth-1:0];
                  part_normal_in = '0;
                  part_s_in      = '0;
                  field_in       = sfta_pkg::FieldNormal;
               end
               sfta_pkg::FieldNormal: begin
                  part_normal_in = req_word[sfta_pkg::IndexWidth-1:0];
                  field_in       = sfta_pkg::FieldS;
               end
               sfta_pkg::FieldS: begin
                  part_s_in = req_word;
                  field_in  = sfta_pkg::FieldT;
               end
               default: begin
                  field_in = sfta_pkg::FieldVertex;
                  if (ordinal_ff == 16'd0) begin
                     slot_in[0] = rec;
                  end else if (ordinal_ff == 16'd1) begin
                     slot_in[2] = rec;
                  end else if (ordinal_ff == 16'd2) begin
                     slot_in[1] = rec;
                  end else if (fan_ff) begin
                     slot_in[2] = slot_ff[1];
                     slot_in[1] = rec;
                  end else if (ordinal_ff[0]) begin
                     slot_in[0] = slot_ff[2];
                     slot_in[2] = rec;
                  end else begin
                     slot_in[0] = slot_ff[1];
                     slot_in[1] = rec;
                  end
                  ordinal_in = ordinal_ff + 1'b1;
                  if (left_ff != '0) begin
                     left_in = left_ff - 1'b1;
                  end
                  if (left_ff <= 16'd1) begin
                     awaiting_in = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // triangle output sequencing
   always_comb begin
      busy_in   = busy_ff;
      corner_in = corner_ff;
      priority if (emit) begin
         busy_in   = 1'b1;
         corner_in = sfta_pkg::CornerFirst;
      end else if (rsp_fire) begin
         if (corner_ff == sfta_pkg::CornerLast) begin
            busy_in = 1'b0;
         end else begin
            corner_in = corner_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b1;
         fan_ff      <= 1'b0;
         left_ff     <= '0;
         ordinal_ff  <= '0;
         field_ff    <= sfta_pkg::FieldVertex;
         busy_ff     <= 1'b0;
         corner_ff   <= sfta_pkg::CornerFirst;
      end else begin
         awaiting_ff <= awaiting_in;
         fan_ff      <= fan_in;
         left_ff     <= left_in;
         ordinal_ff  <= ordinal_in;
         field_ff    <= field_in;
         busy_ff     <= busy_in;
         corner_ff   <= corner_in;
      end
   end

   always_ff @(posedge clock) begin
      part_vertex_ff <= part_vertex_in;
      part_normal_ff <= part_normal_in;
      part_s_ff      <= part_s_in;
      slot_ff        <= slot_in;
   end

   always_comb begin
      unique case (corner_ff)
         sfta_pkg::CornerFirst:  out_corner = slot_ff[0];
         sfta_pkg::CornerSecond: out_corner = slot_ff[1];
         sfta_pkg::CornerLast:   out_corner = slot_ff[2];
         default:                out_corner = slot_ff[0];
      endcase
   end

   assign rsp_valid        = busy_ff;
   assign rsp_vertex_index = out_corner.vertex_index;
   assign rsp_normal_index = out_corner.normal_index;
   assign rsp_tex_s        = out_corner.tex_s;
   assign rsp_tex_t        = out_corner.tex_t;
   assign rsp_last_corner  = (corner_ff == sfta_pkg::CornerLast);

endmodule

>>> hdl/sfta_checker.sv
// ----------------------------------------------------------------------------
// sfta_checker
// Port-level checks of the strip and fan triangle assembler.
// ----------------------------------------------------------------------------
module sfta_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [sfta_pkg::IndexWidth-1:0]       rsp_vertex_index,
   input logic [sfta_pkg::IndexWidth-1:0]       rsp_normal_index,
   input logic signed [sfta_pkg::WordWidth-1:0] rsp_tex_s,
   input logic signed [sfta_pkg::WordWidth-1:0] rsp_tex_t,
   input logic                                  rsp_last_corner
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vertex_index)
         && $stable(rsp_normal_index) && $stable(rsp_tex_s) && $stable(rsp_tex_t)
         && $stable(rsp_last_corner))
      else $error("result word changed while stalled");

   // a triangle is never cut short
   a_tri_whole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_corner |=> rsp_valid)
      else $error("triangle ended before its last corner");

   // rsp_valid drops after the last corner of a triangle is taken
   a_tri_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_corner |=> !rsp_valid)
      else $error("result word right after last corner");

   // a triangle only follows an accepted word
   a_tri_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("triangle without an accepted word");

endmodule

bind strip_fan_triangle_assembler sfta_checker u_sfta_checker (.*);
